// ===== rtl/mm2_pkg.sv =====
// Package with the constants, command and status types shared by the MurmurHash2 unit.
package mm2_pkg;

    localparam logic [31:0] MixMul     = 32'h5bd1e995;
    localparam int          WordShift  = 24;
    localparam int          FinalShiftA = 13;
    localparam int          FinalShiftB = 15;
    localparam logic [31:0] SeedReset  = 32'd5381;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K2,
        ST_H,
        ST_TAIL,
        ST_AVAL
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_K2,
        OP_H,
        OP_TAIL,
        OP_AVAL
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic in_full;
        logic in_empty;
        logic in_last;
        logic item_last;
    } t_status;

endpackage

// ===== rtl/mm2_if.sv =====
// Handshake interfaces for the input word channel and the hash result channel.
interface mm2_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;
    logic [31:0] message_length;

    modport source (output valid, data_word, byte_count, last_item, message_length,
                    input ready);
    modport sink   (input valid, data_word, byte_count, last_item, message_length,
                    output ready);
endinterface

interface mm2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic        format_error;

    modport source (output valid, hash_value, format_error, input ready);
    modport sink   (input valid, hash_value, format_error, output ready);
endinterface

// ===== rtl/mm2_ctrl.sv =====
// Controller state machine that sequences the shared multiplier of the hash datapath.
module mm2_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mm2_pkg::t_cmd   o_cmd,
    input  mm2_pkg::t_status i_status
);

    mm2_pkg::t_state r_state;
    mm2_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_set;
    logic            out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm2_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = mm2_pkg::OP_NONE;
        o_in_ready = 1'b0;
        out_set    = 1'b0;
        case (r_state)
            mm2_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = mm2_pkg::OP_LOAD;
                    if (i_status.in_full) begin
                        n_state = mm2_pkg::ST_K2;
                    end else if (i_status.in_last) begin
                        // An empty tail goes straight to the final avalanche.
                        n_state = i_status.in_empty ? mm2_pkg::ST_AVAL : mm2_pkg::ST_TAIL;
                    end else begin
                        n_state = mm2_pkg::ST_IDLE;
                    end
                end
            end
            mm2_pkg::ST_K2: begin
                o_cmd.op = mm2_pkg::OP_K2;
                n_state  = mm2_pkg::ST_H;
            end
            mm2_pkg::ST_H: begin
                o_cmd.op = mm2_pkg::OP_H;
                n_state  = i_status.item_last ? mm2_pkg::ST_AVAL : mm2_pkg::ST_IDLE;
            end
            mm2_pkg::ST_TAIL: begin
                o_cmd.op = mm2_pkg::OP_TAIL;
                n_state  = mm2_pkg::ST_AVAL;
            end
            mm2_pkg::ST_AVAL: begin
                // The result waits here until the output register can take it.
                if (out_free) begin
                    o_cmd.op = mm2_pkg::OP_AVAL;
                    out_set  = 1'b1;
                    n_state  = mm2_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mm2_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_set) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

// ===== rtl/mm2_dp.sv =====
// Datapath of the hash unit: seed register, running hash and one shared multiplier.
module mm2_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic [31:0]      i_data_word,
    input  logic [2:0]       i_byte_count,
    input  logic             i_last_item,
    input  logic [31:0]      i_message_length,
    input  mm2_pkg::t_cmd    i_cmd,
    output mm2_pkg::t_status o_status,
    output logic [31:0]      o_hash_value,
    output logic             o_format_error
);

    logic [31:0] r_seed;
    logic        r_inside;
    logic        r_err;
    logic [31:0] r_hash;
    logic [31:0] r_k;
    logic [31:0] r_word;
    logic [2:0]  r_count;
    logic        r_last;
    logic [31:0] r_out_hash;
    logic        r_out_err;

    logic [31:0] mul_a;
    logic [31:0] product;
    logic [31:0] tail_mask;
    logic        start;
    logic        short_early;

    assign start       = !r_inside;
    assign short_early = !i_byte_count[2] && !i_last_item;

    assign o_status.in_full   = i_byte_count[2];
    assign o_status.in_empty  = (i_byte_count == 3'd0);
    assign o_status.in_last   = i_last_item;
    assign o_status.item_last = r_last;

    assign o_hash_value   = r_out_hash;
    assign o_format_error = r_out_err;

    always_comb begin
        case (r_count)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            3'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            mm2_pkg::OP_LOAD: mul_a = i_data_word;
            mm2_pkg::OP_K2:   mul_a = r_k ^ (r_k >> mm2_pkg::WordShift);
            mm2_pkg::OP_H:    mul_a = r_hash;
            mm2_pkg::OP_TAIL: mul_a = r_hash ^ (r_word & tail_mask);
            mm2_pkg::OP_AVAL: mul_a = r_hash ^ (r_hash >> mm2_pkg::FinalShiftA);
            default:          mul_a = 32'd0;
        endcase
    end

    // Only the low half of the product is kept, as in 32-bit wrapping arithmetic.
    assign product = mul_a * mm2_pkg::MixMul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= mm2_pkg::SeedReset;
            r_inside <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.op == mm2_pkg::OP_LOAD) begin
                r_inside <= !i_last_item;
                r_err    <= (start ? 1'b0 : r_err) | short_early;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mm2_pkg::OP_LOAD: begin
                r_word  <= i_data_word;
                r_count <= i_byte_count;
                r_last  <= i_last_item;
                r_k     <= product;
                if (start) begin
                    r_hash <= r_seed ^ i_message_length;
                end
            end
            mm2_pkg::OP_K2: begin
                r_k <= product;
            end
            mm2_pkg::OP_H: begin
                r_hash <= product ^ r_k;
            end
            mm2_pkg::OP_TAIL: begin
                r_hash <= product;
            end
            mm2_pkg::OP_AVAL: begin
                r_out_hash <= product ^ (product >> mm2_pkg::FinalShiftB);
                r_out_err  <= r_err;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/murmur2_stream_hash_unit.sv =====
// Top level of the MurmurHash2 stream hash unit: controller and datapath joined.
//
//  channel     | direction | payload                                         | handshake
//  i_in_item   | in        | data_word, byte_count, last_item, message_length | valid/ready
//  o_out_res   | out       | hash_value, format_error                        | valid/ready
//  i_cfg_*     | in        | hash_seed write data                            | write enable
//
// A full word uses the single shared 32x32 multiplier in turn (k, then mixed k, then
// the running hash). A last item adds an avalanche step: after the hash step for a
// full word, after a tail mix for 1-3 bytes, straight after the load for an empty
// tail. A short word before the end is only loaded. Reset is synchronous and active
// low and restores the seed to 5381. A result held in the output register does not
// stop the next word being taken; only the avalanche step waits for it to drain.
module murmur2_stream_hash_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    mm2_in_if.sink       i_in_item,
    mm2_out_if.source    o_out_res
);

    mm2_pkg::t_cmd    cmd;
    mm2_pkg::t_status status;
    logic             in_ready;
    logic             out_valid;
    logic [31:0]      hash_value;
    logic             format_error;

    mm2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out_res.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    mm2_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_data_word      (i_in_item.data_word),
        .i_byte_count     (i_in_item.byte_count),
        .i_last_item      (i_in_item.last_item),
        .i_message_length (i_in_item.message_length),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_hash_value     (hash_value),
        .o_format_error   (format_error)
    );

    assign i_in_item.ready        = in_ready;
    assign o_out_res.valid        = out_valid;
    assign o_out_res.hash_value   = hash_value;
    assign o_out_res.format_error = format_error;

endmodule

// ===== rtl/mm2_chk.sv =====
// Port-level checker for the hash unit, with the bind that attaches it to the top level.
module mm2_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [2:0]  i_in_byte_count,
    input logic        i_in_last_item,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_hash_value
);

    // A result word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    // A stalled result word keeps its hash.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_hash_value))
        else $error("result hash changed while stalled");

    // A full word occupies the multiplier, so the next cycle cannot take a word.
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_byte_count[2] |=> !i_in_ready)
        else $error("input taken while a full word was still being mixed");

    // A short word before the end is dropped at once and the input stays open.
    a_short_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_byte_count[2] && !i_in_last_item |=> i_in_ready)
        else $error("short word before the end held up the input");

    // A new result only appears directly after a work step in which no input was taken.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a preceding avalanche cycle");

endmodule

bind murmur2_stream_hash_unit mm2_chk u_mm2_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_item.valid),
    .i_in_ready       (i_in_item.ready),
    .i_in_byte_count  (i_in_item.byte_count),
    .i_in_last_item   (i_in_item.last_item),
    .i_out_valid      (o_out_res.valid),
    .i_out_ready      (o_out_res.ready),
    .i_out_hash_value (o_out_res.hash_value)
);
